[src/bpd_pkg.sv]
package bpd_pkg;

   // Default for the largest accepted image dimension.
   localparam int unsigned MAX_DIM_DEFAULT = 4096;

   // File signature and supported pixel depths.
   localparam logic [7:0]  MAGIC_B      = 8'h42;
   localparam logic [7:0]  MAGIC_M      = 8'h4D;
   localparam logic [15:0] DEPTH_24     = 16'd24;
   localparam logic [15:0] DEPTH_32     = 16'd32;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

   // Header byte positions (little-endian fields, last byte of each).
   localparam logic [31:0] FILE_HDR_BYTES = 32'd14;
   localparam logic [31:0] POS_MAGIC_0    = 32'd0;
   localparam logic [31:0] POS_MAGIC_1    = 32'd1;
   localparam logic [31:0] POS_OFFSET_END = FILE_HDR_BYTES - 32'd1;
   localparam logic [31:0] POS_WIDTH_END  = FILE_HDR_BYTES + 32'd7;
   localparam logic [31:0] POS_HEIGHT_END = FILE_HDR_BYTES + 32'd11;
   localparam logic [31:0] POS_DEPTH_END  = FILE_HDR_BYTES + 32'd15;
   localparam logic [31:0] HDR_END        = 32'd54;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_PIXEL     = 2'd0,
      STATUS_BAD_MAGIC = 2'd1,
      STATUS_BAD_DEPTH = 2'd2,
      STATUS_BAD_SIZE  = 2'd3
   } status_type;

   // One input beat as seen by the parser.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_req;
   } bpd_item_type;

   // One parser result; hit marks that the beat produced a result.
   typedef struct packed {
      logic       hit;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [11:0] col;
      logic [11:0] row;
      status_type status;
      logic       last;
   } bpd_result_type;

endpackage

[src/bpd_req_if.sv]
interface bpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_req;

   modport source (output valid, output data_byte, output start_req, input ready);
   modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

[src/bpd_rsp_if.sv]
interface bpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  alpha;
   logic [11:0] col;
   logic [11:0] row;
   logic [1:0]  status;
   logic        last;

   modport source (output valid, output red, output green, output blue, output alpha,
                   output col, output row, output status, output last, input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   input col, input row, input status, input last, output ready);
endinterface

[src/bmp_pixel_stream_decoder_core.sv]
// Streaming decoder for uncompressed 24-bit and 32-bit BMP files. Feed the file one byte per
// beat on req, with start_req set on the first byte; each pixel comes out on rsp as RGBA
// (alpha 255 for 24-bit data) in file order with its column and its row counted from the
// top. Header problems (bad signature, depth other than 24/32, size zero or above MAX_DIM,
// negative width, pixel offset below 54) give a single result with a nonzero status and last
// set, after which bytes are dropped until the next start. The block takes one byte every
// cycle: each byte passes an input register, one level of parser logic and an output
// register, and rsp back-pressure stalls the input only once both registers are full.
module bmp_pixel_stream_decoder_core import bpd_pkg::*; #(
   parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   bpd_req_if.sink   req,
   bpd_rsp_if.source rsp
);

   logic           in_valid_ff, in_valid_in;
   bpd_item_type   in_item_ff;
   logic           out_valid_ff, out_valid_in;
   bpd_result_type out_data_ff;
   bpd_result_type result;
   logic           out_free;
   logic           advance;
   logic           req_beat;

   // Handshake: the input register moves on when the output register can take a result.
   assign out_free    = !out_valid_ff || rsp.ready;
   assign advance     = in_valid_ff && out_free;
   assign req.ready   = !in_valid_ff || advance;
   assign req_beat    = req.valid && req.ready;
   assign in_valid_in = req_beat || (in_valid_ff && !advance);
   assign out_valid_in = advance && result.hit;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_item_ff.data_byte <= req.data_byte;
         in_item_ff.start_req <= req.start_req;
      end
   end

   bpd_parser #(
      .MAX_DIM (MAX_DIM)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= result;
      end
   end

   assign rsp.valid  = out_valid_ff;
   assign rsp.red    = out_data_ff.red;
   assign rsp.green  = out_data_ff.green;
   assign rsp.blue   = out_data_ff.blue;
   assign rsp.alpha  = out_data_ff.alpha;
   assign rsp.col    = out_data_ff.col;
   assign rsp.row    = out_data_ff.row;
   assign rsp.status = out_data_ff.status;
   assign rsp.last   = out_data_ff.last;

endmodule

[src/bpd_parser.sv]
module bpd_parser import bpd_pkg::*; #(
   parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  bpd_item_type   item,
   output bpd_result_type result
);

   localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
   localparam logic [31:0] MAX_DIM32 = 32'(MAX_DIM);

   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_HEADER = 6'b000010,
      PH_SKIP   = 6'b000100,
      PH_PIXELS = 6'b001000,
      PH_PAD    = 6'b010000,
      PH_DONE   = 6'b100000
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [31:0]      pos_ff, pos_in;
   logic [31:0]      shift_ff, shift_in;
   logic [31:0]      offset_ff, offset_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic             width_bad_ff, width_bad_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             height_bad_ff, height_bad_in;
   logic             bottom_up_ff, bottom_up_in;
   logic             four_byte_ff, four_byte_in;
   logic [DIM_W-1:0] col_ff, col_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic [1:0]       bip_ff, bip_in;
   logic [1:0]       pad_ff, pad_in;
   logic [23:0]      hold_ff, hold_in;

   // Values after an optional restart, as seen by this beat.
   phase_type        cur_phase;
   logic [31:0]      cur_pos;
   logic [31:0]      shift_src;
   logic [31:0]      shift_new;
   logic [31:0]      pos_plus;
   logic [31:0]      h_mag;
   logic [15:0]      depth;
   logic [DIM_W-1:0] col_plus;
   logic [DIM_W-1:0] row_plus;
   logic [DIM_W-1:0] dest_row;
   logic [DIM_W+1:0] width_ext;
   logic [DIM_W+11:0] col_ext;
   logic [DIM_W+11:0] row_ext;
   logic [1:0]       last_byte;
   logic [1:0]       row_pad;
   logic             pix_last;
   logic [7:0]       b;
   bpd_result_type   res;

   assign b         = item.data_byte;
   assign cur_phase = item.start_req ? PH_HEADER : phase_ff;
   assign cur_pos   = item.start_req ? '0 : pos_ff;
   assign shift_src = item.start_req ? '0 : shift_ff;
   assign shift_new = {b, shift_src[31:8]};
   assign pos_plus  = cur_pos + 32'd1;
   assign h_mag     = shift_new[31] ? (32'd0 - shift_new) : shift_new;
   assign depth     = shift_new[31:16];
   assign col_plus  = col_ff + 1'b1;
   assign row_plus  = row_ff + 1'b1;
   assign dest_row  = bottom_up_ff ? (height_ff - 1'b1 - row_ff) : row_ff;
   assign width_ext = {2'b00, width_ff};
   assign col_ext   = {12'd0, col_ff};
   assign row_ext   = {12'd0, dest_row};
   assign last_byte = four_byte_ff ? 2'd3 : 2'd2;
   // Rows of 3-byte pixels pad by width mod 4; 4-byte rows never pad.
   assign row_pad   = four_byte_ff ? 2'd0 : width_ext[1:0];
   assign pix_last  = (col_plus == width_ff) && (row_plus == height_ff);

   // Next state and result for the beat at the parser input.
   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      shift_in      = shift_ff;
      offset_in     = offset_ff;
      width_in      = width_ff;
      width_bad_in  = width_bad_ff;
      height_in     = height_ff;
      height_bad_in = height_bad_ff;
      bottom_up_in  = bottom_up_ff;
      four_byte_in  = four_byte_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      bip_in        = bip_ff;
      pad_in        = pad_ff;
      hold_in       = hold_ff;
      res           = '0;
      res.status    = STATUS_PIXEL;

      // A start beat abandons any file in progress.
      if (item.start_req) begin
         phase_in = PH_HEADER;
         pos_in   = '0;
         col_in   = '0;
         row_in   = '0;
         bip_in   = '0;
         pad_in   = '0;
      end

      unique case (cur_phase)
         PH_HEADER: begin
            shift_in = shift_new;
            priority if ((cur_pos == POS_MAGIC_0 && b != MAGIC_B) ||
                         (cur_pos == POS_MAGIC_1 && b != MAGIC_M)) begin
               res.hit    = 1'b1;
               res.status = STATUS_BAD_MAGIC;
               res.last   = 1'b1;
               phase_in   = PH_DONE;
            end else if (cur_pos == POS_DEPTH_END &&
                         depth != DEPTH_24 && depth != DEPTH_32) begin
               res.hit    = 1'b1;
               res.status = STATUS_BAD_DEPTH;
               res.last   = 1'b1;
               phase_in   = PH_DONE;
            end else if (cur_pos == POS_DEPTH_END &&
                         (width_bad_ff || height_bad_ff || offset_ff < HDR_END)) begin
               res.hit    = 1'b1;
               res.status = STATUS_BAD_SIZE;
               res.last   = 1'b1;
               phase_in   = PH_DONE;
            end else begin
               // Capture header fields as their last byte arrives.
               if (cur_pos == POS_OFFSET_END) begin
                  offset_in = shift_new;
               end
               if (cur_pos == POS_WIDTH_END) begin
                  width_in     = shift_new[DIM_W-1:0];
                  width_bad_in = (shift_new == 32'd0) || shift_new[31] ||
                                 (shift_new > MAX_DIM32);
               end
               if (cur_pos == POS_HEIGHT_END) begin
                  height_in     = h_mag[DIM_W-1:0];
                  height_bad_in = (h_mag == 32'd0) || (h_mag > MAX_DIM32);
                  bottom_up_in  = !shift_new[31];
               end
               if (cur_pos == POS_DEPTH_END) begin
                  four_byte_in = (depth == DEPTH_32);
               end
               pos_in = pos_plus;
               if (pos_plus == HDR_END) begin
                  phase_in = (offset_ff == HDR_END) ? PH_PIXELS : PH_SKIP;
               end
            end
         end

         PH_SKIP: begin
            pos_in = pos_plus;
            if (pos_plus == offset_ff) begin
               phase_in = PH_PIXELS;
            end
         end

         PH_PIXELS: begin
            if (bip_ff != last_byte) begin
               // Collect blue, green and, for 32-bit pixels, red bytes of the pixel.
               unique case (bip_ff)
                  2'd0:    hold_in[7:0]   = b;
                  2'd1:    hold_in[15:8]  = b;
                  default: hold_in[23:16] = b;
               endcase
               bip_in = bip_ff + 2'd1;
            end else begin
               bip_in     = '0;
               res.hit    = 1'b1;
               res.blue   = hold_ff[7:0];
               res.green  = hold_ff[15:8];
               res.red    = four_byte_ff ? hold_ff[23:16] : b;
               res.alpha  = four_byte_ff ? b : ALPHA_OPAQUE;
               res.col    = col_ext[11:0];
               res.row    = row_ext[11:0];
               res.status = STATUS_PIXEL;
               res.last   = pix_last;
               if (pix_last) begin
                  phase_in = PH_DONE;
               end else if (col_plus == width_ff) begin
                  if (row_pad == 2'd0) begin
                     col_in = '0;
                     row_in = row_plus;
                  end else begin
                     col_in   = col_plus;
                     pad_in   = row_pad;
                     phase_in = PH_PAD;
                  end
               end else begin
                  col_in = col_plus;
               end
            end
         end

         PH_PAD: begin
            pad_in = pad_ff - 2'd1;
            if (pad_ff == 2'd1) begin
               col_in   = '0;
               row_in   = row_plus;
               phase_in = PH_PIXELS;
            end
         end

         default: begin
         end
      endcase

      res.hit = res.hit && fire;
   end

   assign result = res;

   // Parser state registers advance once per accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         bip_ff   <= '0;
         pad_ff   <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         bip_ff   <= bip_in;
         pad_ff   <= pad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         shift_ff      <= shift_in;
         offset_ff     <= offset_in;
         width_ff      <= width_in;
         width_bad_ff  <= width_bad_in;
         height_ff     <= height_in;
         height_bad_ff <= height_bad_in;
         bottom_up_ff  <= bottom_up_in;
         four_byte_ff  <= four_byte_in;
         hold_ff       <= hold_in;
      end
   end

`ifndef SYNTHESIS
   // The final pixel or an error always leaves the parser finished.
   assert property (@(posedge clock) disable iff (reset)
      result.hit && result.last |=> phase_ff == PH_DONE)
      else $error("parser not finished after last result");

   // A fourth byte position is only used for 32-bit pixels.
   assert property (@(posedge clock) disable iff (reset)
      bip_ff == 2'd3 |-> four_byte_ff)
      else $error("fourth pixel byte in 24-bit mode");

   // While collecting pixels the column stays inside the row.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PIXELS |-> col_ff < width_ff)
      else $error("column outside image width");

   // Padding is only skipped while bytes remain to skip.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAD |-> pad_ff != 2'd0)
      else $error("padding phase with nothing to skip");
`endif

endmodule
